// ===== sv/tfn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_pkg: shared types and constants for the triangle face normal block
// Output format, divider step count and queue sizing.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int OUT_FRAC    = 14;
  localparam int OUT_WIDTH   = 16;
  localparam int DIV_STEPS   = OUT_FRAC + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = QUEUE_AW + 1;

  typedef struct packed {
    logic full;
    logic empty;
  } tfn_q_stat_t;

endpackage

// ===== sv/triangle_face_normal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal: unit face normal of one triangle
// Cross product of edges a-b and a-c, integer square-root length, normalized to signed Q1.14.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with the nine corner coordinates, signed
// POS_WIDTH-bit fixed point. Result channel: out_valid/out_ready with the
// three normal components and a degenerate flag (zero cross product gives a
// zero normal with the flag set).
// Throughput: one triangle per cycle sustained while out_ready holds. Most of
// the pipeline is the square root (one root bit per stage) and the fifteen
// quotient stages of the divider.
// The front computes edges and cross product and fills a four-entry queue;
// the back pipeline pulls from it. When the receiver stalls, the back
// pipeline holds, the queue fills and in_ready drops once the front is full.
// Reset (rst_n, synchronous, active low) empties the pipelines and queue.
// ----------------------------------------------------------------------------
module triangle_face_normal #(
  parameter int POS_WIDTH = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [POS_WIDTH-1:0]           in_a_x,
  input  logic signed [POS_WIDTH-1:0]           in_a_y,
  input  logic signed [POS_WIDTH-1:0]           in_a_z,
  input  logic signed [POS_WIDTH-1:0]           in_b_x,
  input  logic signed [POS_WIDTH-1:0]           in_b_y,
  input  logic signed [POS_WIDTH-1:0]           in_b_z,
  input  logic signed [POS_WIDTH-1:0]           in_c_x,
  input  logic signed [POS_WIDTH-1:0]           in_c_y,
  input  logic signed [POS_WIDTH-1:0]           in_c_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [tfn_pkg::OUT_WIDTH-1:0]  out_normal_x,
  output logic signed [tfn_pkg::OUT_WIDTH-1:0]  out_normal_y,
  output logic signed [tfn_pkg::OUT_WIDTH-1:0]  out_normal_z,
  output logic                                  out_degenerate
);

  localparam int CW = 2 * POS_WIDTH + 2;

  tfn_pkg::tfn_q_stat_t  q_stat;
  logic                  push_valid;
  logic signed [CW-1:0]  push_x, push_y, push_z;
  logic [3*CW-1:0]       head_data;
  logic                  pop;

  tfn_front #(.POS_WIDTH(POS_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_a_x     (in_a_x),
    .in_a_y     (in_a_y),
    .in_a_z     (in_a_z),
    .in_b_x     (in_b_x),
    .in_b_y     (in_b_y),
    .in_b_z     (in_b_z),
    .in_c_x     (in_c_x),
    .in_c_y     (in_c_y),
    .in_c_z     (in_c_z),
    .q_stat     (q_stat),
    .push_valid (push_valid),
    .push_x     (push_x),
    .push_y     (push_y),
    .push_z     (push_z)
  );

  tfn_queue #(.DW(3 * CW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  ({push_z, push_y, push_x}),
    .pop        (pop),
    .head_data  (head_data),
    .q_stat     (q_stat)
  );

  tfn_back #(.POS_WIDTH(POS_WIDTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .head_data      (head_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_normal_x   (out_normal_x),
    .out_normal_y   (out_normal_y),
    .out_normal_z   (out_normal_z),
    .out_degenerate (out_degenerate)
  );

endmodule

// ===== sv/tfn_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_front: edge vectors and exact cross product
// Two register stages; pushes the signed cross product into the queue.
// ----------------------------------------------------------------------------
module tfn_front #(
  parameter int POS_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [POS_WIDTH-1:0]   in_a_x,
  input  logic signed [POS_WIDTH-1:0]   in_a_y,
  input  logic signed [POS_WIDTH-1:0]   in_a_z,
  input  logic signed [POS_WIDTH-1:0]   in_b_x,
  input  logic signed [POS_WIDTH-1:0]   in_b_y,
  input  logic signed [POS_WIDTH-1:0]   in_b_z,
  input  logic signed [POS_WIDTH-1:0]   in_c_x,
  input  logic signed [POS_WIDTH-1:0]   in_c_y,
  input  logic signed [POS_WIDTH-1:0]   in_c_z,
  input  tfn_pkg::tfn_q_stat_t          q_stat,
  output logic                          push_valid,
  output logic signed [2*POS_WIDTH+1:0] push_x,
  output logic signed [2*POS_WIDTH+1:0] push_y,
  output logic signed [2*POS_WIDTH+1:0] push_z
);

  localparam int EW = POS_WIDTH + 1;
  localparam int CW = 2 * POS_WIDTH + 2;

  logic                 en;
  logic                 f1_v_r, f2_v_r;
  logic signed [EW-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  logic signed [CW-1:0] cx_r, cy_r, cz_r;
  logic signed [CW-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;

  assign en       = !(f2_v_r && q_stat.full);
  assign in_ready = en;

  assign p_yz = e1y_r * e2z_r;
  assign p_zy = e1z_r * e2y_r;
  assign p_zx = e1z_r * e2x_r;
  assign p_xz = e1x_r * e2z_r;
  assign p_xy = e1x_r * e2y_r;
  assign p_yx = e1y_r * e2x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1x_r <= EW'(in_a_x) - EW'(in_b_x);
      e1y_r <= EW'(in_a_y) - EW'(in_b_y);
      e1z_r <= EW'(in_a_z) - EW'(in_b_z);
      e2x_r <= EW'(in_a_x) - EW'(in_c_x);
      e2y_r <= EW'(in_a_y) - EW'(in_c_y);
      e2z_r <= EW'(in_a_z) - EW'(in_c_z);
      cx_r  <= p_yz - p_zy;
      cy_r  <= p_zx - p_xz;
      cz_r  <= p_xy - p_yx;
    end
  end

  assign push_valid = f2_v_r;
  assign push_x     = cx_r;
  assign push_y     = cy_r;
  assign push_z     = cz_r;

endmodule

// ===== sv/tfn_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_queue: short queue between front and back
// Holds cross products so each side can stall on its own.
// ----------------------------------------------------------------------------
module tfn_queue #(
  parameter int DW = 78
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  input  logic [DW-1:0]        push_data,
  input  logic                 pop,
  output logic [DW-1:0]        head_data,
  output tfn_pkg::tfn_q_stat_t q_stat
);

  logic [DW-1:0]                   mem_r [tfn_pkg::QUEUE_DEPTH];
  logic [tfn_pkg::QUEUE_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [tfn_pkg::QUEUE_CW-1:0]    count_r, count_nxt;
  logic                            do_push, do_pop;

  assign q_stat.full  = (count_r == tfn_pkg::QUEUE_CW'(tfn_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push_valid && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_data    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= tfn_pkg::QUEUE_CW'(tfn_pkg::QUEUE_DEPTH))
    else $error("queue count over depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue empty with pointers apart");

endmodule

// ===== sv/tfn_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_back: length and normalize pipeline
// Squares, sum, one root bit per stage, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tfn_back #(
  parameter int POS_WIDTH = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tfn_pkg::tfn_q_stat_t                  q_stat,
  input  logic [3*(2*POS_WIDTH+2)-1:0]          head_data,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [tfn_pkg::OUT_WIDTH-1:0]  out_normal_x,
  output logic signed [tfn_pkg::OUT_WIDTH-1:0]  out_normal_y,
  output logic signed [tfn_pkg::OUT_WIDTH-1:0]  out_normal_z,
  output logic                                  out_degenerate
);

  localparam int MW  = 2 * POS_WIDTH + 2;
  localparam int H   = (MW + 1) / 2;
  localparam int HW  = MW - H;
  localparam int SQW = 2 * MW;
  localparam int R   = MW + 1;
  localparam int SW  = 2 * R;
  localparam int RW  = R + 3;
  localparam int DW  = R + 1;
  localparam int QW  = tfn_pkg::DIV_STEPS;
  localparam int OW  = tfn_pkg::OUT_WIDTH;

  logic en;

  // stage b0: magnitude and sign
  logic                  b0_v_r;
  logic [2:0][MW-1:0]    b0_mag_r;
  logic [2:0]            b0_neg_r;
  // stage b1: partial products of the squares
  logic                  b1_v_r;
  logic [2:0][MW-1:0]    b1_mag_r;
  logic [2:0]            b1_neg_r;
  logic [2:0][2*HW-1:0]  b1_hh_r;
  logic [2:0][MW-1:0]    b1_hl_r;
  logic [2:0][2*H-1:0]   b1_ll_r;
  // stage b2: full squares
  logic                  b2_v_r;
  logic [2:0][MW-1:0]    b2_mag_r;
  logic [2:0]            b2_neg_r;
  logic [2:0][SQW-1:0]   b2_sq_r;

  // root stages
  logic                  s_v_r    [R+1];
  logic [2:0][MW-1:0]    s_mag_r  [R+1];
  logic [2:0]            s_neg_r  [R+1];
  logic                  s_zero_r [R+1];
  logic [SW-1:0]         s_sum_r  [R+1];
  logic [RW-1:0]         s_rem_r  [R+1];
  logic [R-1:0]          s_root_r [R+1];

  // divide stages
  logic                  d_v_r    [QW+1];
  logic [2:0]            d_neg_r  [QW+1];
  logic                  d_zero_r [QW+1];
  logic [R-1:0]          d_len_r  [QW+1];
  logic [2:0][DW-1:0]    d_rem_r  [QW+1];
  logic [2:0][QW-1:0]    d_q_r    [QW+1];

  logic                  out_valid_r;
  logic signed [OW-1:0]  out_x_r, out_y_r, out_z_r;
  logic                  out_deg_r;

  assign en  = !out_valid_r || out_ready;
  assign pop = en && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r <= 1'b0;
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      s_v_r[0] <= 1'b0;
    end else if (en) begin
      b0_v_r <= !q_stat.empty;
      b1_v_r <= b0_v_r;
      b2_v_r <= b1_v_r;
      s_v_r[0] <= b2_v_r;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_sq
    logic signed [MW-1:0] c;
    logic [HW-1:0]        hi;
    logic [H-1:0]         lo;
    assign c  = head_data[k*MW +: MW];
    assign hi = b0_mag_r[k][MW-1:H];
    assign lo = b0_mag_r[k][H-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        b0_mag_r[k] <= c[MW-1] ? MW'(-c) : MW'(c);
        b0_neg_r[k] <= c[MW-1];
        b1_mag_r[k] <= b0_mag_r[k];
        b1_neg_r[k] <= b0_neg_r[k];
        b1_hh_r[k]  <= hi * hi;
        b1_hl_r[k]  <= hi * lo;
        b1_ll_r[k]  <= lo * lo;
        b2_mag_r[k] <= b1_mag_r[k];
        b2_neg_r[k] <= b1_neg_r[k];
        b2_sq_r[k]  <= (SQW'(b1_hh_r[k]) << (2 * H)) + (SQW'(b1_hl_r[k]) << (H + 1))
                       + SQW'(b1_ll_r[k]);
      end
    end
  end

  logic [SW-1:0] sum_nxt;
  assign sum_nxt = SW'(b2_sq_r[0]) + SW'(b2_sq_r[1]) + SW'(b2_sq_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      s_mag_r[0]  <= b2_mag_r;
      s_neg_r[0]  <= b2_neg_r;
      s_sum_r[0]  <= sum_nxt;
      s_zero_r[0] <= (sum_nxt == '0);
      s_rem_r[0]  <= '0;
      s_root_r[0] <= '0;
    end
  end

  // restoring square root, two radicand bits per stage
  for (genvar i = 0; i < R; i++) begin : g_root
    logic [RW-1:0] cur, trial;
    logic          ge;
    assign cur   = {s_rem_r[i][RW-3:0], s_sum_r[i][SW-1-2*i -: 2]};
    assign trial = RW'({s_root_r[i], 2'b01});
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_v_r[i+1] <= 1'b0;
      end else if (en) begin
        s_v_r[i+1] <= s_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_mag_r[i+1]  <= s_mag_r[i];
        s_neg_r[i+1]  <= s_neg_r[i];
        s_zero_r[i+1] <= s_zero_r[i];
        s_sum_r[i+1]  <= s_sum_r[i];
        s_rem_r[i+1]  <= ge ? (cur - trial) : cur;
        s_root_r[i+1] <= {s_root_r[i][R-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r[0] <= 1'b0;
    end else if (en) begin
      d_v_r[0] <= s_v_r[R];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_neg_r[0]  <= s_neg_r[R];
      d_zero_r[0] <= s_zero_r[R];
      d_len_r[0]  <= s_root_r[R];
      d_q_r[0]    <= '0;
      for (int k = 0; k < 3; k++) begin
        d_rem_r[0][k] <= DW'(s_mag_r[R][k]);
      end
    end
  end

  // restoring divide of magnitude by length, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [2:0][DW-1:0] rem_nxt;
    logic [2:0][QW-1:0] q_nxt;
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        if (d_rem_r[j][k] >= DW'(d_len_r[j])) begin
          rem_nxt[k] = (d_rem_r[j][k] - DW'(d_len_r[j])) << 1;
          q_nxt[k]   = {d_q_r[j][k][QW-2:0], 1'b1};
        end else begin
          rem_nxt[k] = d_rem_r[j][k] << 1;
          q_nxt[k]   = {d_q_r[j][k][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_v_r[j+1] <= 1'b0;
      end else if (en) begin
        d_v_r[j+1] <= d_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_neg_r[j+1]  <= d_neg_r[j];
        d_zero_r[j+1] <= d_zero_r[j];
        d_len_r[j+1]  <= d_len_r[j];
        d_rem_r[j+1]  <= rem_nxt;
        d_q_r[j+1]    <= q_nxt;
      end
    end
  end

  function automatic logic signed [OW-1:0] apply_sign(input logic [QW-1:0] q,
                                                        input logic neg, input logic zero);
    logic [OW-1:0] m;
    m = OW'(q);
    if (zero) return '0;
    return neg ? -m : m;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r   <= apply_sign(d_q_r[QW][0], d_neg_r[QW][0], d_zero_r[QW]);
      out_y_r   <= apply_sign(d_q_r[QW][1], d_neg_r[QW][1], d_zero_r[QW]);
      out_z_r   <= apply_sign(d_q_r[QW][2], d_neg_r[QW][2], d_zero_r[QW]);
      out_deg_r <= d_zero_r[QW];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_normal_x   = out_x_r;
  assign out_normal_y   = out_y_r;
  assign out_normal_z   = out_z_r;
  assign out_degenerate = out_deg_r;

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_deg_r) |-> (out_x_r == '0 && out_y_r == '0 && out_z_r == '0))
    else $error("degenerate result with nonzero normal");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_x_r <= 16384 && out_x_r >= -16384 &&
                     out_y_r <= 16384 && out_y_r >= -16384 &&
                     out_z_r <= 16384 && out_z_r >= -16384))
    else $error("normal component out of range");

  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    d_v_r[0] |-> (d_zero_r[0] == (d_len_r[0] == '0)))
    else $error("zero flag disagrees with root");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(d_q_r[QW]))
    else $error("pipeline moved while stalled");

endmodule

// ===== tb/tb_triangle_face_normal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_face_normal: self-checking bench for the face normal block
// Drives triangles with random gaps, predicts each normal with exact wide
// integer math and checks results in order under random output stalls.
// ----------------------------------------------------------------------------

class normal_scoreboard;
  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degen;
  } normal_t;

  normal_t pending[$];
  int      errors;

  // floor(sqrt(s)) by one root bit per step
  function automatic logic [71:0] isqrt(logic [143:0] s);
    logic [71:0]  r;
    logic [71:0]  t;
    r = '0;
    for (int b = 70; b >= 0; b--) begin
      t = r | (72'd1 << b);
      if (144'(t) * 144'(t) <= s) r = t;
    end
    return r;
  endfunction

  function automatic void note_triangle(logic signed [23:0] p[9]);
    logic signed [25:0] e1[3];
    logic signed [25:0] e2[3];
    logic signed [53:0] n[3];
    logic        [53:0] m[3];
    logic [143:0] sum;
    logic [71:0]  len;
    logic [15:0]  q[3];
    normal_t      e;
    for (int k = 0; k < 3; k++) begin
      e1[k] = 26'(p[k]) - 26'(p[3+k]);
      e2[k] = 26'(p[k]) - 26'(p[6+k]);
    end
    n[0] = 54'(e1[1]) * 54'(e2[2]) - 54'(e1[2]) * 54'(e2[1]);
    n[1] = 54'(e1[2]) * 54'(e2[0]) - 54'(e1[0]) * 54'(e2[2]);
    n[2] = 54'(e1[0]) * 54'(e2[1]) - 54'(e1[1]) * 54'(e2[0]);
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      m[k] = n[k] < 0 ? 54'(-n[k]) : 54'(n[k]);
      sum += 144'(m[k]) * 144'(m[k]);
    end
    if (sum == 0) begin
      e = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
    end else begin
      len = isqrt(sum);
      for (int k = 0; k < 3; k++) begin
        q[k] = 16'((144'(m[k]) << 14) / 144'(len));
        if (n[k] < 0) q[k] = -q[k];
      end
      e = '{q[0], q[1], q[2], 1'b0};
    end
    pending.push_back(e);
  endfunction

  function automatic void check_normal(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                      logic d, realtime t);
    normal_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h %h %h %b", t, x, y, z, d);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e.nx !== x || e.ny !== y || e.nz !== z || e.degen !== d) begin
      $display("%0t: expected %h %h %h %b, actual %h %h %h %b",
               t, e.nx, e.ny, e.nz, e.degen, x, y, z, d);
      errors++;
    end
  endfunction
endclass

module tb_triangle_face_normal;

  localparam int NUM_RANDOM = 1000;
  localparam int MAX_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [23:0] pos[9];
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [tfn_pkg::OUT_WIDTH-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_degenerate;
  logic stim_done = 1'b0;
  int   cycles = 0;
  normal_scoreboard normals = new();

  always #1 clk = ~clk;

  initial for (int i = 0; i < 9; i++) pos[i] = '0;

  triangle_face_normal u_dut (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_a_x(pos[0]), .in_a_y(pos[1]), .in_a_z(pos[2]),
    .in_b_x(pos[3]), .in_b_y(pos[4]), .in_b_z(pos[5]),
    .in_c_x(pos[6]), .in_c_y(pos[7]), .in_c_z(pos[8]),
    .out_valid, .out_ready, .out_normal_x, .out_normal_y, .out_normal_z,
    .out_degenerate
  );

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // request held until accepted at a rising edge
  task automatic send_triangle(logic signed [23:0] p[9]);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    pos = p;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    normals.note_triangle(p);
    @(negedge clk);
  endtask

  function automatic logic signed [23:0] rand_coord(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 31)) - 24'sd16;
      2: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      default: return 24'($urandom_range(0, 4095)) - 24'sd2048;
    endcase
  endfunction

  initial begin
    logic signed [23:0] p[9];
    int mode;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    // directed: extremes, coincident, collinear, axis-aligned
    for (int i = 0; i < 9; i++) p[i] = '0;
    send_triangle(p);
    p = '{24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh800000, 24'sh800000, 24'sh800000,
          24'sh7fffff, 24'sh800000, 24'sh7fffff};
    send_triangle(p);
    p = '{24'sh800000, 24'sh7fffff, 24'sh0, 24'sh7fffff, 24'sh800000, 24'sh7fffff,
          24'sh0, 24'sh0, 24'sh800000};
    send_triangle(p);
    p = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};
    send_triangle(p);
    p = '{0, 0, 0, 0, 4096, 0, 4096, 0, 0};
    send_triangle(p);
    p = '{0, 0, 0, 0, 0, 1, 1, 0, 0};
    send_triangle(p);
    p = '{1, 2, 3, 2, 4, 6, 3, 6, 9};
    send_triangle(p);
    p = '{5, 5, 5, 5, 5, 5, -7, 3, 9};
    send_triangle(p);
    p = '{24'sh800000, 24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh800000, 24'sh800000,
          24'sh800000, 24'sh7fffff, 24'sh800000};
    send_triangle(p);
    p = '{1, 1, 1, 2, 1, 1, 1, 1, 2};
    send_triangle(p);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 9; i++) p[i] = rand_coord(mode);
      // some collinear triangles so the flag shows up under random traffic
      if ($urandom_range(0, 15) == 0)
        for (int i = 0; i < 3; i++) p[6+i] = p[3+i];
      send_triangle(p);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver with random stalls
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else begin
        g = gap_len();
        if (g == 0 || $urandom_range(0, 1)) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (g - 1) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      normals.check_normal(out_normal_x, out_normal_y, out_normal_z, out_degenerate, $realtime);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("tb_triangle_face_normal failed");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (normals.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (normals.errors == 0 && normals.pending.size() == 0) begin
      $display("tb_triangle_face_normal passed");
    end else begin
      $display("tb_triangle_face_normal failed");
    end
    $finish;
  end
endmodule
